// ----- src/u8s_pkg.sv -----
package u8s_pkg;

    localparam int SymMax = 4;
    localparam int SymCntW = 3;
    localparam int PendDepth = 3;

    localparam logic [7:0] ReplByte0 = 8'hEF;
    localparam logic [7:0] ReplByte1 = 8'hBF;
    localparam logic [7:0] ReplByte2 = 8'hBD;

    localparam logic [1:0] ReplSubFirst = 2'd0;
    localparam logic [1:0] ReplSubMid = 2'd1;
    localparam logic [1:0] ReplSubLast = 2'd2;

    localparam logic [2:0] LenBad = 3'd0;
    localparam logic [2:0] LenAscii = 3'd1;
    localparam logic [2:0] LenTwo = 3'd2;
    localparam logic [2:0] LenThree = 3'd3;
    localparam logic [2:0] LenFour = 3'd4;

    typedef struct packed {
        logic       repl;
        logic [7:0] data;
    } t_sym;

    typedef struct packed {
        t_sym [SymMax-1:0]   syms;
        logic [SymCntW-1:0]  count;
        logic                last;
    } t_burst;

    function automatic logic [2:0] f_lead_len(input logic [7:0] c);
        logic [2:0] len;
        len = LenBad;
        if (c[7] == 1'b0) begin
            len = LenAscii;
        end else if (c[7:5] == 3'b110) begin
            len = LenTwo;
        end else if (c[7:4] == 4'b1110) begin
            len = LenThree;
        end else if (c[7:3] == 5'b11110) begin
            len = LenFour;
        end
        return len;
    endfunction

    function automatic logic [7:0] f_repl_byte(input logic [1:0] sub);
        logic [7:0] b;
        unique case (sub)
            ReplSubFirst: b = ReplByte0;
            ReplSubMid:   b = ReplByte1;
            default:      b = ReplByte2;
        endcase
        return b;
    endfunction

endpackage

// ----- src/u8s_emit.sv -----
module u8s_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  u8s_pkg::t_burst i_burst,
    output logic            o_free,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata,  // [7:0] out_byte
    output logic            o_m_tlast   // out_last
);
    import u8s_pkg::*;

    t_sym [SymMax-1:0]  r_syms;
    logic [SymCntW-1:0] r_nsym;
    logic [1:0]         r_sub;
    logic               r_last;

    logic sym_done;
    logic final_byte;
    logic take;

    assign sym_done   = !r_syms[0].repl || (r_sub == ReplSubLast);
    assign final_byte = (r_nsym == SymCntW'(1)) && sym_done;
    assign take       = o_m_tvalid && i_m_tready;

    assign o_m_tvalid = (r_nsym != '0);
    assign o_m_tdata  = r_syms[0].repl ? f_repl_byte(r_sub) : r_syms[0].data;
    assign o_m_tlast  = r_last && final_byte;
    assign o_free     = (r_nsym == '0) || (i_m_tready && final_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nsym <= '0;
            r_sub  <= ReplSubFirst;
        end else if (i_load) begin
            r_nsym <= i_burst.count;
            r_sub  <= ReplSubFirst;
        end else if (take) begin
            if (sym_done) begin
                r_nsym <= r_nsym - SymCntW'(1);
                r_sub  <= ReplSubFirst;
            end else begin
                r_sub <= r_sub + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_syms <= i_burst.syms;
            r_last <= i_burst.last;
        end else if (take && sym_done) begin
            r_syms <= {t_sym'('0), r_syms[SymMax-1:1]};
        end
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("burst loaded while previous burst still pending");

    a_sub_in_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_sub != ReplSubFirst) |-> r_syms[0].repl)
        else $error("replacement step on a plain byte");

    a_nsym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nsym <= SymCntW'(SymMax)) && (r_sub != 2'd3))
        else $error("emitter counters out of range");
`endif

endmodule

// ----- src/utf8_stream_sanitizer.sv -----
// UTF-8 stream sanitizer.
// Input stream: i_s_tdata carries one raw byte, i_s_tlast marks the last byte
// of a stream. Output stream: o_m_tdata carries one sanitized byte, o_m_tlast
// is high on the final output byte of the stream.
// Multi-byte sequences are held back until complete or broken; bad lead
// bytes, broken sequences and sequences cut off by tlast are replaced by
// EF BF BD per offending byte. One input byte may release 0 to 12 bytes.
// An accepted input's output bytes, if any, are registered in the emitter,
// which drives the first of them on the output port. Throughput: one input byte per
// cycle while each byte releases at most one output byte and i_m_tready stays
// high; an input that releases more than one byte holds the input side until
// its last byte is being transferred by the single output byte serializer.
// Reset (i_rst_n low, synchronous) drops any held sequence and any output
// still queued. When the receiver holds i_m_tready low, the current output
// byte stays on the port; one further input transaction is taken only once
// the queued output drains down to its last byte being transferred.
module utf8_stream_sanitizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // in_last
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast    // out_last
);
    import u8s_pkg::*;

    logic [7:0] r_pend [PendDepth];
    logic [1:0] r_pend_cnt;
    logic [2:0] r_exp_len;
    logic [1:0] n_pend_cnt;
    logic [2:0] n_exp_len;

    logic       accept;
    logic       free;
    logic       active;
    logic       is_cont;
    logic [2:0] lead_len;
    logic       complete;
    logic       store;
    logic       judge;
    logic       judge_sym;
    logic       new_lead;
    logic [1:0] flush_cnt;
    logic [1:0] cnt_after;
    logic [1:0] tail_cnt;
    logic [2:0] judge_pos;
    logic [2:0] list_end;
    t_burst     burst;

    assign accept = i_s_tvalid && o_s_tready;
    assign o_s_tready = free;

    assign active    = (r_pend_cnt != 2'd0);
    assign is_cont   = (i_s_tdata[7:6] == 2'b10);
    assign lead_len  = f_lead_len(i_s_tdata);
    assign complete  = active && is_cont && (({1'b0, r_pend_cnt} + 3'd1) >= r_exp_len);
    assign store     = active && is_cont && !complete;
    assign judge     = !active || !is_cont;
    assign new_lead  = judge && (lead_len >= LenTwo);
    assign judge_sym = judge && !new_lead;
    assign flush_cnt = (active && !is_cont) ? r_pend_cnt : 2'd0;

    always_comb begin
        if (new_lead) begin
            cnt_after = 2'd1;
        end else if (store) begin
            cnt_after = r_pend_cnt + 2'd1;
        end else begin
            cnt_after = 2'd0;
        end
    end

    assign tail_cnt  = i_s_tlast ? cnt_after : 2'd0;
    assign judge_pos = {1'b0, flush_cnt};
    assign list_end  = judge_pos + {2'b00, judge_sym} + {1'b0, tail_cnt};

    always_comb begin
        burst = '0;
        burst.last = i_s_tlast;
        if (complete) begin
            burst.count = {1'b0, r_pend_cnt} + 3'd1;
            for (int k = 0; k < PendDepth; k++) begin
                burst.syms[k].repl = 1'b0;
                burst.syms[k].data = (2'(k) == r_pend_cnt) ? i_s_tdata : r_pend[k];
            end
            burst.syms[SymMax-1].repl = 1'b0;
            burst.syms[SymMax-1].data = i_s_tdata;
        end else begin
            burst.count = list_end;
            for (int k = 0; k < SymMax; k++) begin
                if (judge_sym && (3'(k) == judge_pos)) begin
                    burst.syms[k].repl = (lead_len == LenBad);
                    burst.syms[k].data = i_s_tdata;
                end else begin
                    burst.syms[k].repl = 1'b1;
                    burst.syms[k].data = '0;
                end
            end
        end
    end

    always_comb begin
        if (i_s_tlast) begin
            n_pend_cnt = 2'd0;
            n_exp_len  = 3'd0;
        end else begin
            n_pend_cnt = cnt_after;
            if (new_lead) begin
                n_exp_len = lead_len;
            end else if (store) begin
                n_exp_len = r_exp_len;
            end else begin
                n_exp_len = 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= 2'd0;
            r_exp_len  <= 3'd0;
        end else if (accept) begin
            r_pend_cnt <= n_pend_cnt;
            r_exp_len  <= n_exp_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < PendDepth; k++) begin
                if ((new_lead && k == 0) || (store && 2'(k) == r_pend_cnt)) begin
                    r_pend[k] <= i_s_tdata;
                end
            end
        end
    end

    u8s_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_burst    (burst),
        .o_free     (free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

`ifndef SYNTHESIS
    a_pend_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_cnt != 2'd0) |-> (r_exp_len > {1'b0, r_pend_cnt}) && (r_exp_len <= LenFour))
        else $error("held sequence longer than its lead allows");

    a_idle_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_cnt == 2'd0) |-> (r_exp_len == 3'd0))
        else $error("sequence length kept with nothing held");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_tlast) |=> (r_pend_cnt == 2'd0) && o_m_tvalid)
        else $error("end of stream left a sequence open or no output");
`endif

endmodule
